### hw/rtl/fsnc_pkg.sv
// ----------------------------------------------------------------------------
// fsnc_pkg
// Shared characters, status codes and queue status type for the short-name
// converter.
// ----------------------------------------------------------------------------
package fsnc_pkg;

  localparam int CHAR_W = 8;
  localparam int IDX_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_BSLASH = 8'h5C;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/fsnc_front.sv
// ----------------------------------------------------------------------------
// fsnc_front
// Character parser: builds the padded short name one character per beat and
// pushes the finished name, or an error mark, into the name queue.
// ----------------------------------------------------------------------------
module fsnc_front #(
  parameter int BASE_LENGTH = 8,
  parameter int NAME_LENGTH = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_name_char,
  input  logic                        in_first_of_name,
  input  fsnc_pkg::q_stat_t           q_stat,
  output logic                        push_valid,
  output logic                        push_err,
  output logic [NAME_LENGTH*8-1:0]    push_name
);
  import fsnc_pkg::*;

  localparam int MAX_LEN   = (BASE_LENGTH > NAME_LENGTH) ? BASE_LENGTH : NAME_LENGTH;
  localparam int FW        = $clog2(MAX_LEN + 1);
  localparam int EXT_START = (BASE_LENGTH < NAME_LENGTH) ? BASE_LENGTH : NAME_LENGTH;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BASE,
    PH_DOTOPT,
    PH_EXT,
    PH_LDOT,
    PH_LDOTDOT
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [7:0]      name_r   [NAME_LENGTH];
  logic [7:0]      name_nxt [NAME_LENGTH];

  logic            accept;
  logic            is_term, is_dot;
  logic            do_base, do_ext, base_end;
  logic            wr_en, set_dot0, set_dot1, emit, err, clr;
  logic [FW-1:0]   fcur, f1;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_term   = (in_name_char == CHAR_NUL) || (in_name_char == CHAR_BSLASH);
    is_dot    = (in_name_char == CHAR_DOT);
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    fcur      = fill_r;
    do_base   = 1'b0;
    do_ext    = 1'b0;
    base_end  = 1'b0;
    wr_en     = 1'b0;
    set_dot0  = 1'b0;
    set_dot1  = 1'b0;
    emit      = 1'b0;
    err       = 1'b0;
    clr       = 1'b0;

    if (in_first_of_name) begin
      clr      = 1'b1;
      fcur     = '0;
      fill_nxt = '0;
      if ((in_name_char == CHAR_SPACE) || (in_name_char == CHAR_NUL)) begin
        err = 1'b1;
      end else if (is_dot) begin
        fill_nxt  = FW'(EXT_START);
        phase_nxt = PH_LDOT;
      end else begin
        do_base = 1'b1;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          phase_nxt = PH_IDLE;
        end
        PH_BASE: begin
          do_base = 1'b1;
        end
        PH_DOTOPT: begin
          if (is_dot) begin
            phase_nxt = PH_EXT;
          end else begin
            do_ext = 1'b1;
          end
        end
        PH_EXT: begin
          do_ext = 1'b1;
        end
        PH_LDOT: begin
          if (is_term) begin
            set_dot0 = 1'b1;
            emit     = 1'b1;
          end else if (is_dot) begin
            phase_nxt = PH_LDOTDOT;
          end else if (fill_r >= FW'(NAME_LENGTH)) begin
            emit = 1'b1;
          end else begin
            do_ext = 1'b1;
          end
        end
        PH_LDOTDOT: begin
          if (is_term) begin
            set_dot0 = 1'b1;
            set_dot1 = 1'b1;
            emit     = 1'b1;
          end else if (fill_r >= FW'(NAME_LENGTH)) begin
            emit = 1'b1;
          end else begin
            do_ext = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    f1 = fcur + 1'b1;

    if (do_base) begin
      if (is_term) begin
        emit = 1'b1;
      end else if (is_dot) begin
        base_end = 1'b1;
      end else begin
        wr_en = (fcur < FW'(NAME_LENGTH));
        if (f1 >= FW'(BASE_LENGTH)) begin
          base_end = 1'b1;
        end else begin
          fill_nxt  = f1;
          phase_nxt = PH_BASE;
        end
      end
    end

    if (do_ext) begin
      if (is_term) begin
        emit = 1'b1;
      end else begin
        wr_en    = (fcur < FW'(NAME_LENGTH));
        fill_nxt = f1;
        if (f1 >= FW'(NAME_LENGTH)) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_EXT;
        end
      end
    end

    if (base_end) begin
      fill_nxt = FW'(EXT_START);
      if (EXT_START >= NAME_LENGTH) begin
        emit = 1'b1;
      end else begin
        phase_nxt = PH_DOTOPT;
      end
    end

    if (emit || err) begin
      phase_nxt = PH_IDLE;
    end

    for (int i = 0; i < NAME_LENGTH; i++) begin
      name_nxt[i] = clr ? CHAR_SPACE : name_r[i];
      if (wr_en && (fcur == FW'(i))) begin
        name_nxt[i] = in_name_char;
      end
    end
    if (set_dot0) begin
      name_nxt[0] = CHAR_DOT;
    end
    if (set_dot1) begin
      name_nxt[1] = CHAR_DOT;
    end

    for (int i = 0; i < NAME_LENGTH; i++) begin
      push_name[i*8 +: 8] = name_nxt[i];
    end
  end

  assign push_valid = accept && (emit || err);
  assign push_err   = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fill_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_r <= name_nxt;
    end
  end

endmodule

### hw/rtl/fsnc_queue.sv
// ----------------------------------------------------------------------------
// fsnc_queue
// Two-entry queue of finished names between the parser and the serializer.
// ----------------------------------------------------------------------------
module fsnc_queue #(
  parameter int NAME_LENGTH = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  logic                        push_err,
  input  logic [NAME_LENGTH*8-1:0]    push_name,
  input  logic                        pop,
  output fsnc_pkg::q_stat_t           q_stat,
  output logic                        head_err,
  output logic [NAME_LENGTH*8-1:0]    head_name
);
  import fsnc_pkg::*;

  localparam int EW = NAME_LENGTH * 8 + 1;

  logic [EW-1:0] slot_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r, count_nxt;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign {head_err, head_name} = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push_valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= {push_err, push_name};
    end
  end

endmodule

### hw/rtl/fsnc_back.sv
// ----------------------------------------------------------------------------
// fsnc_back
// Serializer: sends the head name of the queue one byte per beat through a
// registered output stage, or a single error beat.
// ----------------------------------------------------------------------------
module fsnc_back #(
  parameter int NAME_LENGTH = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsnc_pkg::q_stat_t           q_stat,
  input  logic                        head_err,
  input  logic [NAME_LENGTH*8-1:0]    head_name,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_name_byte,
  output logic [3:0]                  out_byte_index,
  output logic                        out_status,
  output logic                        out_last_byte
);
  import fsnc_pkg::*;

  localparam int IW = $clog2(NAME_LENGTH);

  logic          out_valid_r;
  logic [7:0]    byte_r;
  logic [3:0]    idx_r;
  logic          status_r;
  logic          last_r;
  logic [IW-1:0] pos_r;

  logic          load;
  logic          at_end;

  assign load   = !q_stat.empty && (!out_valid_r || out_ready);
  assign at_end = (pos_r == IW'(NAME_LENGTH - 1));
  assign pop    = load && (head_err || at_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      if (head_err || at_end) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_err) begin
        byte_r   <= CHAR_NUL;
        idx_r    <= '0;
        status_r <= STATUS_BAD;
        last_r   <= 1'b1;
      end else begin
        byte_r   <= head_name[pos_r*8 +: 8];
        idx_r    <= IDX_W'(pos_r);
        status_r <= STATUS_OK;
        last_r   <= at_end;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_name_byte  = byte_r;
  assign out_byte_index = idx_r;
  assign out_status     = status_r;
  assign out_last_byte  = last_r;

endmodule

### hw/rtl/fat_short_name_converter_core.sv
// ----------------------------------------------------------------------------
// fat_short_name_converter_core
// Converts path component characters into padded 8.3 directory-entry names.
// ----------------------------------------------------------------------------
// The parser takes one character per cycle while in_ready is high and finishes
// a name in the cycle of its terminating character or of the one that fills
// the name. Each finished name goes into a two-entry queue; the serializer
// then sends NAME_LENGTH bytes, one per cycle while out_ready is high, or one
// error beat. A name holds its queue slot until its last byte is loaded into
// the output register. Input is held off while both queue slots are taken, one
// of them possibly part way through serialization, so one character per cycle
// is sustained while components average at least NAME_LENGTH characters; the
// serializer's one byte per cycle sets the output side's limit.
module fat_short_name_converter_core #(
  parameter int BASE_LENGTH = 8,
  parameter int NAME_LENGTH = 11
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_name_char,
  input  logic       in_first_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_name_byte,
  output logic [3:0] out_byte_index,
  output logic       out_status,
  output logic       out_last_byte
);
  import fsnc_pkg::*;

  q_stat_t                     q_stat;
  logic                        push_valid;
  logic                        push_err;
  logic [NAME_LENGTH*8-1:0]    push_name;
  logic                        pop;
  logic                        head_err;
  logic [NAME_LENGTH*8-1:0]    head_name;

  fsnc_front #(
    .BASE_LENGTH(BASE_LENGTH),
    .NAME_LENGTH(NAME_LENGTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_name_char    (in_name_char),
    .in_first_of_name(in_first_of_name),
    .q_stat          (q_stat),
    .push_valid      (push_valid),
    .push_err        (push_err),
    .push_name       (push_name)
  );

  fsnc_queue #(
    .NAME_LENGTH(NAME_LENGTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_err  (push_err),
    .push_name (push_name),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_err  (head_err),
    .head_name (head_name)
  );

  fsnc_back #(
    .NAME_LENGTH(NAME_LENGTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_err      (head_err),
    .head_name     (head_name),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_name_byte (out_name_byte),
    .out_byte_index(out_byte_index),
    .out_status    (out_status),
    .out_last_byte (out_last_byte)
  );

endmodule

### hw/rtl/fsnc_checker.sv
// ----------------------------------------------------------------------------
// fsnc_checker
// Port-level checks on the result stream of the short-name converter.
// ----------------------------------------------------------------------------
module fsnc_checker #(
  parameter int NAME_LENGTH = 11
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_name_byte,
  input logic [3:0] out_byte_index,
  input logic       out_status,
  input logic       out_last_byte
);
  import fsnc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_name_byte)
      && $stable(out_byte_index) && $stable(out_status) && $stable(out_last_byte))
    else $error("result beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_BAD) |->
      out_last_byte && (out_byte_index == 4'd0) && (out_name_byte == CHAR_NUL))
    else $error("error beat malformed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte && (out_status == STATUS_OK) |->
      out_byte_index == 4'(NAME_LENGTH - 1))
    else $error("name ended at wrong byte index");

  a_next_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=> out_valid
      && (out_status == STATUS_OK)
      && (out_byte_index == 4'($past(out_byte_index) + 4'd1)))
    else $error("name bytes not contiguous");

endmodule

bind fat_short_name_converter_core fsnc_checker #(
  .NAME_LENGTH(NAME_LENGTH)
) u_fsnc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_name_byte (out_name_byte),
  .out_byte_index(out_byte_index),
  .out_status    (out_status),
  .out_last_byte (out_last_byte)
);
